// ----- src/grt_pkg.sv -----
// Shared types and constants for the glyph text renderer.
// Used by grt_ctrl and glyph_text_renderer_top; no dependencies.
`default_nettype none

package grt_pkg;

    // Font and store geometry
    localparam int GLYPH_COUNT      = 256;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int GLYPH_WIDTH      = 8;

    localparam int CODE_W  = $clog2(GLYPH_COUNT);
    localparam int ROW_W   = $clog2(MAX_GLYPH_HEIGHT);
    localparam int ADDR_W  = CODE_W + ROW_W;
    localparam int BITS_W  = GLYPH_WIDTH;

    // Field widths
    localparam int COORD_W = 13;
    localparam int INDEX_W = 26;
    localparam int COLOR_W = 32;
    localparam int HGT_W   = 6;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
    localparam logic [HGT_W-1:0]   HGT_MAX   = HGT_W'(MAX_GLYPH_HEIGHT);

    // Stream packing
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 288;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_DRAW  = 2'd1,
        FN_PLACE = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR  = 3'd0,
        CFG_BG_COLOR  = 3'd1,
        CFG_WIDTH     = 3'd2,
        CFG_PITCH     = 3'd3,
        CFG_HEIGHT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_ROWS,
        ST_ADV
    } state_t;

    // Glyph store access from the sequencer
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [BITS_W-1:0] wdata;
    } ram_req_t;

    // Row whose glyph bits sit in the store's read register
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               last;
    } row_t;

endpackage

`default_nettype wire

// ----- src/glyph_text_renderer_top.sv -----
// Glyph text renderer top level: stream ports, configuration registers,
// glyph store and output register. Depends on grt_pkg, grt_glyph_ram, grt_ctrl.
//
// Input channel s_*: one item per command. s_tuser carries func (load glyph row,
// draw character, place cursor). Load and place give no result. A draw of a
// glyph with h rows (glyph_height clamped to 1..32) gives h result items on
// m_*, one per glyph row, m_tlast high on the final row. A draw occupies the
// sequencer through its states in order: taking the item, the cursor row times
// pitch product, the base index add, the row reads (one glyph store read and
// one index add per cycle through the shared adder while the output does not
// stall) and the cursor advance. s_tready is low meanwhile.
// Results leave through an output register: a stalled receiver holds m_tdata
// and pauses the row reads, and a new item is taken while the last row waits.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block itself does not enforce this.
// Reset restores the register defaults and homes the cursor; glyph store
// contents are undefined until loaded.
`default_nettype none

module glyph_text_renderer_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // item: char_code, row_index, row_bits, place_x, place_y (from bit 0)
    input  wire logic [grt_pkg::IN_DATA_W-1:0]       s_tdata,
    // item: func
    input  wire logic [1:0]                          s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // item: pixel_index, pix_0 .. pix_7 (from bit 0)
    output logic [grt_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_we,
    input  wire logic [grt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [grt_pkg::CFG_W-1:0]           cfg_data
);

    import grt_pkg::*;

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic [COORD_W-1:0] width_reg, pitch_reg;
    logic [HGT_W-1:0]   height_reg;

    ram_req_t           ram_req;
    row_t               row;
    logic [BITS_W-1:0]  rd_bits;
    logic               take;

    logic               m_vld_reg, m_vld_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg     <= '1;
            bg_reg     <= '0;
            width_reg  <= COORD_W'(1024);
            pitch_reg  <= COORD_W'(1024);
            height_reg <= HGT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FG_COLOR: fg_reg     <= cfg_data[COLOR_W-1:0];
                CFG_BG_COLOR: bg_reg     <= cfg_data[COLOR_W-1:0];
                CFG_WIDTH:    width_reg  <= cfg_data[COORD_W-1:0];
                CFG_PITCH:    pitch_reg  <= cfg_data[COORD_W-1:0];
                CFG_HEIGHT:   height_reg <= cfg_data[HGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    grt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .func           (func_t'(s_tuser)),
        .char_code      (s_tdata[7:0]),
        .row_index      (s_tdata[12:8]),
        .row_bits       (s_tdata[20:13]),
        .place_x        (s_tdata[33:21]),
        .place_y        (s_tdata[46:34]),
        .frame_width    (width_reg),
        .scanline_pitch (pitch_reg),
        .glyph_height   (height_reg),
        .ram_req        (ram_req),
        .row            (row),
        .take           (take)
    );

    grt_glyph_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (BITS_W)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rd_bits)
    );

    // Move the pending row into the output register when it is free
    assign take = row.valid && (!m_vld_reg || m_tready);

    // Expand glyph bits into colors, leftmost pixel from the top bit
    always_comb
    begin
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        if (m_vld_reg && m_tready)
        begin
            m_vld_next = 1'b0;
        end
        if (take)
        begin
            m_vld_next = 1'b1;
            m_last_next = row.last;
            m_data_next = '0;
            m_data_next[INDEX_W-1:0] = row.index;
            for (int c = 0; c < GLYPH_WIDTH; c++)
            begin
                m_data_next[INDEX_W + c*COLOR_W +: COLOR_W] =
                    rd_bits[GLYPH_WIDTH-1-c] ? fg_reg : bg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output item changed while stalled");

    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!m_vld_reg || m_tready))
        else $error("row loaded over an undelivered item");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:INDEX_W + GLYPH_WIDTH*COLOR_W] == '0))
        else $error("output padding bits not zero");
`endif

endmodule

`default_nettype wire

// ----- src/grt_glyph_ram.sv -----
// Generic single-port RAM with a registered read, used as the glyph store.
// No dependencies.
`default_nettype none

module grt_glyph_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write and read; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/grt_ctrl.sv -----
// Sequencer for the glyph text renderer: cursor, shared index adder, row issue.
// Depends on grt_pkg; drives the glyph store request.
`default_nettype none

module grt_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire grt_pkg::func_t                 func,
    input  wire logic [grt_pkg::CODE_W-1:0]     char_code,
    input  wire logic [grt_pkg::ROW_W-1:0]      row_index,
    input  wire logic [grt_pkg::BITS_W-1:0]     row_bits,
    input  wire logic [grt_pkg::COORD_W-1:0]    place_x,
    input  wire logic [grt_pkg::COORD_W-1:0]    place_y,
    input  wire logic [grt_pkg::COORD_W-1:0]    frame_width,
    input  wire logic [grt_pkg::COORD_W-1:0]    scanline_pitch,
    input  wire logic [grt_pkg::HGT_W-1:0]      glyph_height,
    output grt_pkg::ram_req_t                   ram_req,
    output grt_pkg::row_t                       row,
    input  wire logic                           take
);

    import grt_pkg::*;

    state_t               state_reg, state_next;
    logic [COORD_W-1:0]   col_reg, col_next;
    logic [COORD_W-1:0]   crow_reg, crow_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [ROW_W-1:0]     hm1_reg, hm1_next;
    logic [ROW_W-1:0]     rcnt_reg, rcnt_next;
    logic [INDEX_W-1:0]   prod_reg, prod_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [INDEX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                 rd_last_reg, rd_last_next;

    logic [INDEX_W-1:0]   add_a, add_b, add_sum;
    logic                 accept;
    logic                 issue;
    logic                 last_issue;
    logic [ROW_W-1:0]     hm1_in;
    logic [COORD_W:0]     col_plus8;
    logic                 wrap;

    // Shared adder: base index, per-row index step, line advance
    assign add_sum = add_a + add_b;

    always_comb
    begin
        case (state_reg)
            ST_BASE:
            begin
                add_a = prod_reg;
                add_b = INDEX_W'(col_reg);
            end
            ST_ADV:
            begin
                add_a = INDEX_W'(crow_reg);
                add_b = INDEX_W'(hm1_reg) + INDEX_W'(1);
            end
            default:
            begin
                add_a = idx_reg;
                add_b = INDEX_W'(scanline_pitch);
            end
        endcase
    end

    // Clamp the glyph height to 1..MAX and keep it as height minus one
    always_comb
    begin
        if (glyph_height == '0)
        begin
            hm1_in = '0;
        end
        else if (glyph_height > HGT_MAX)
        begin
            hm1_in = ROW_W'(MAX_GLYPH_HEIGHT - 1);
        end
        else
        begin
            hm1_in = ROW_W'(glyph_height - HGT_W'(1));
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign issue      = (state_reg == ST_ROWS) && (!rd_vld_reg || take);
    assign last_issue = issue && (rcnt_reg == hm1_reg);

    // Cursor wrap: next column plus one glyph past the visible width
    assign col_plus8 = {1'b0, col_reg} + (COORD_W+1)'(GLYPH_WIDTH);
    assign wrap      = ({1'b0, col_reg} + (COORD_W+1)'(2 * GLYPH_WIDTH))
                       > {1'b0, frame_width};

    // Next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        crow_next    = crow_reg;
        code_next    = code_reg;
        hm1_next     = hm1_reg;
        rcnt_next    = rcnt_reg;
        prod_next    = prod_reg;
        idx_next     = idx_reg;
        rd_vld_next  = rd_vld_reg;
        rd_idx_next  = rd_idx_reg;
        rd_last_next = rd_last_reg;

        ram_req.we    = 1'b0;
        ram_req.re    = issue;
        ram_req.addr  = {code_reg, rcnt_reg};
        ram_req.wdata = row_bits;

        // Drop the held row once the output side takes it
        if (take)
        begin
            rd_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_LOAD:
                        begin
                            ram_req.we   = 1'b1;
                            ram_req.addr = {char_code, row_index};
                        end
                        FN_PLACE:
                        begin
                            col_next  = place_x;
                            crow_next = place_y;
                        end
                        FN_DRAW:
                        begin
                            code_next  = char_code;
                            hm1_next   = hm1_in;
                            rcnt_next  = '0;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = INDEX_W'(crow_reg) * INDEX_W'(scanline_pitch);
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                idx_next   = add_sum;
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (issue)
                begin
                    rd_vld_next  = 1'b1;
                    rd_idx_next  = idx_reg;
                    rd_last_next = (rcnt_reg == hm1_reg);
                    idx_next     = add_sum;
                    rcnt_next    = rcnt_reg + ROW_W'(1);
                    if (last_issue)
                    begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV:
            begin
                if (wrap)
                begin
                    col_next = '0;
                    if (add_sum > INDEX_W'(COORD_MAX))
                    begin
                        crow_next = COORD_MAX;
                    end
                    else
                    begin
                        crow_next = add_sum[COORD_W-1:0];
                    end
                end
                else
                begin
                    col_next = col_plus8[COORD_W-1:0];
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            col_reg    <= '0;
            crow_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            crow_reg   <= crow_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        hm1_reg     <= hm1_next;
        rcnt_reg    <= rcnt_next;
        prod_reg    <= prod_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= rd_idx_next;
        rd_last_reg <= rd_last_next;
    end

    assign row.valid = rd_vld_reg;
    assign row.index = rd_idx_reg;
    assign row.last  = rd_last_reg;

`ifndef SYNTH
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("glyph store read and write in the same cycle");

    a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg && !take) |=>
            (rd_vld_reg && $stable(rd_idx_reg) && $stable(rd_last_reg)))
        else $error("pending row changed before it was taken");

    a_last_to_adv: assert property (@(posedge clk) disable iff (!rst_n)
        last_issue |=> (state_reg == ST_ADV) && rd_last_reg)
        else $error("final row issue did not end the draw");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/glyph_text_renderer_checker.sv -----
// Scoreboard for the glyph text renderer: mirrors the glyph store, cursor and
// configuration, predicts the pixel rows of every draw and compares them.
// Depends on grt_pkg.

module glyph_text_renderer_checker
    import grt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [IN_DATA_W-1:0]    s_tdata,
    input  wire logic [1:0]              s_tuser,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [OUT_DATA_W-1:0]   m_tdata,
    input  wire logic                    m_tlast,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    output int                           mismatches,
    output int                           rows_due
);

    // Bit offsets of the item fields in s_tdata
    localparam int F_CODE = 0;
    localparam int F_ROW  = F_CODE + CODE_W;
    localparam int F_BITS = F_ROW + ROW_W;
    localparam int F_X    = F_BITS + BITS_W;
    localparam int F_Y    = F_X + COORD_W;

    typedef struct packed {
        logic [INDEX_W-1:0]                   index;
        logic [GLYPH_WIDTH-1:0][COLOR_W-1:0]  pix;
        logic                                 last;
    } pixel_row_t;

    pixel_row_t          rows_pending[$];

    logic [BITS_W-1:0]   glyph_rows [GLYPH_COUNT*MAX_GLYPH_HEIGHT];
    logic [COORD_W-1:0]  cursor_col;
    logic [COORD_W-1:0]  cursor_row;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic [COORD_W-1:0]  frame_width;
    logic [COORD_W-1:0]  scanline_pitch;
    logic [HGT_W-1:0]    glyph_height;

    // Expand one character into its pixel rows, then advance the cursor
    task automatic render_char(input logic [CODE_W-1:0] code);
        int unsigned        rows;
        int unsigned        r;
        int unsigned        col_next;
        int unsigned        row_next;
        int                 c;
        logic [BITS_W-1:0]  bits;
        pixel_row_t         pr;
        rows = (glyph_height == 0) ? 1 :
               (glyph_height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : glyph_height;
        for (r = 0; r < rows; r++) begin
            bits = glyph_rows[{code, ROW_W'(r)}];
            pr.index = INDEX_W'(cursor_col + (cursor_row + r) * scanline_pitch);
            for (c = 0; c < GLYPH_WIDTH; c++)
                pr.pix[c] = bits[GLYPH_WIDTH-1-c] ? fg_color : bg_color;
            pr.last = (r == rows - 1);
            rows_pending.push_back(pr);
        end
        // wrap to the next text line when the next glyph would not fit
        col_next = cursor_col + GLYPH_WIDTH;
        if (col_next + GLYPH_WIDTH > frame_width) begin
            col_next = 0;
            row_next = cursor_row + rows;
            cursor_row = (row_next > COORD_MAX) ? COORD_MAX : COORD_W'(row_next);
        end
        cursor_col = COORD_W'(col_next);
    endtask

    // Compare one delivered row against the oldest pending one
    task automatic check_row(input logic [OUT_DATA_W-1:0] data, input logic last);
        pixel_row_t          want;
        logic [COLOR_W-1:0]  got_pix;
        int                  c;
        if (rows_pending.size() == 0) begin
            $display("%0t ERROR pixel row with none pending: index %h last %b",
                     $time, data[INDEX_W-1:0], last);
            mismatches++;
            return;
        end
        want = rows_pending.pop_front();
        if (data[INDEX_W-1:0] !== want.index) begin
            $display("%0t ERROR pixel_index: expected %h, got %h",
                     $time, want.index, data[INDEX_W-1:0]);
            mismatches++;
        end
        for (c = 0; c < GLYPH_WIDTH; c++) begin
            got_pix = data[INDEX_W + COLOR_W*c +: COLOR_W];
            if (got_pix !== want.pix[c]) begin
                $display("%0t ERROR pix_%0d: expected %h, got %h",
                         $time, c, want.pix[c], got_pix);
                mismatches++;
            end
        end
        if (last !== want.last) begin
            $display("%0t ERROR last_row: expected %b, got %b", $time, want.last, last);
            mismatches++;
        end
    endtask

    // Track every handshake; results first so a stray row is never masked
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fg_color       = '1;
            bg_color       = '0;
            frame_width    = COORD_W'(1024);
            scanline_pitch = COORD_W'(1024);
            glyph_height   = HGT_W'(16);
            cursor_col     = '0;
            cursor_row     = '0;
            mismatches     = 0;
            rows_pending.delete();
            rows_due <= 0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_row(m_tdata, m_tlast);
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FG_COLOR: fg_color       = cfg_data[COLOR_W-1:0];
                    CFG_BG_COLOR: bg_color       = cfg_data[COLOR_W-1:0];
                    CFG_WIDTH:    frame_width    = cfg_data[COORD_W-1:0];
                    CFG_PITCH:    scanline_pitch = cfg_data[COORD_W-1:0];
                    CFG_HEIGHT:   glyph_height   = cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (func_t'(s_tuser))
                    FN_LOAD:
                        glyph_rows[{s_tdata[F_CODE +: CODE_W], s_tdata[F_ROW +: ROW_W]}] =
                            s_tdata[F_BITS +: BITS_W];
                    FN_DRAW:
                        render_char(s_tdata[F_CODE +: CODE_W]);
                    FN_PLACE: begin
                        cursor_col = s_tdata[F_X +: COORD_W];
                        cursor_row = s_tdata[F_Y +: COORD_W];
                    end
                    default: ;
                endcase
            end
            rows_due <= rows_pending.size();
        end
    end

endmodule

// ----- tb/sv/glyph_text_renderer_top_tb.sv -----
// Testbench top for the glyph text renderer: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on grt_pkg, glyph_text_renderer_top
// and glyph_text_renderer_checker.

module glyph_text_renderer_top_tb;
    import grt_pkg::*;

    localparam int RANDOM_ITEMS  = 370;
    localparam int SETTLE_CYCLES = 8;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;
    logic [1:0]              s_tuser   = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data  = '0;

    int  mismatches;
    int  rows_due;
    int  items_sent  = 0;
    int  font_rows   = 16;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;
    int  stall_left  = 0;
    int  rx_pick;
    bit  row_loaded [GLYPH_COUNT][MAX_GLYPH_HEIGHT];

    glyph_text_renderer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glyph_text_renderer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .rows_due   (rows_due)
    );

    always #5 clk = ~clk;

    // Receiver: short stalls mostly, a few long ones, and calm stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_steady = !rx_steady;
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else begin
            m_tready <= 1'b1;
            if (!rx_steady) begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 20)
                    stall_left = $urandom_range(1, 3);
                else if (rx_pick < 23)
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    // Sender gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        if (tx_steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one command item and hold it until taken
    task automatic send_item(input func_t f, input logic [7:0] code, input logic [4:0] row,
                             input logic [7:0] bits, input logic [12:0] px,
                             input logic [12:0] py);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= IN_DATA_W'({py, px, bits, row, code});
        do @(posedge clk); while (!s_tready);
        if (f != FN_NONE)
            items_sent++;
    endtask

    // Drop valid and hold until every pixel row has been delivered
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rows_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Load every row of one glyph up to the current font height
    task automatic load_glyph(input logic [7:0] code);
        int          r;
        int          pick;
        logic [7:0]  bits;
        for (r = 0; r < font_rows; r++) begin
            pick = $urandom_range(0, 99);
            bits = (pick < 15) ? 8'h00 : (pick < 30) ? 8'hFF : 8'($urandom);
            send_item(FN_LOAD, code, 5'(r), bits, 13'($urandom), 13'($urandom));
            row_loaded[code][r] = 1'b1;
        end
    endtask

    task automatic draw_char(input logic [7:0] code);
        send_item(FN_DRAW, code, 5'($urandom), 8'($urandom), 13'($urandom), 13'($urandom));
    endtask

    task automatic place_cursor(input logic [12:0] px, input logic [12:0] py);
        send_item(FN_PLACE, 8'($urandom), 5'($urandom), 8'($urandom), px, py);
    endtask

    // Find a glyph whose rows are all loaded for the current height
    function automatic int find_ready_glyph();
        int start;
        int i;
        int code;
        int r;
        bit ok;
        start = $urandom_range(0, GLYPH_COUNT - 1);
        for (i = 0; i < GLYPH_COUNT; i++) begin
            code = (start + i) % GLYPH_COUNT;
            ok = 1'b1;
            for (r = 0; r < font_rows; r++)
                if (!row_loaded[code][r])
                    ok = 1'b0;
            if (ok)
                return code;
        end
        return -1;
    endfunction

    // Reconfigure while idle: fixed extreme settings first, then random ones
    task automatic config_phase(input int phase);
        logic [31:0]  fg;
        logic [31:0]  bg;
        logic [12:0]  width;
        logic [12:0]  pitch;
        logic [5:0]   height;
        int           pick;
        bit           all_regs;
        fg = $urandom;
        bg = $urandom;
        width = 13'($urandom_range(16, 8191));
        pitch = 13'($urandom_range(8, 8191));
        pick = $urandom_range(0, 99);
        height = (pick < 70) ? 6'($urandom_range(1, 6)) :
                 (pick < 80) ? 6'd0 :
                 (pick < 90) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(7, 16));
        all_regs = (phase < 4);
        case (phase)
            0: begin fg = '0; bg = '1; width = 13'd8; pitch = 13'd8191; height = 6'd0; end
            1: begin fg = '1; bg = '0; width = 13'd8191; pitch = 13'd8; height = 6'd63; end
            2: begin width = 13'd15; height = 6'd32; end
            3: begin width = 13'd16; pitch = 13'd8191; height = 6'd33; end
            default: begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    width = 13'($urandom_range(8, 15));
                else if (pick < 30)
                    width = 13'd8191;
                if ($urandom_range(0, 9) == 0)
                    fg = '1;
                if ($urandom_range(0, 9) == 0)
                    bg = '0;
            end
        endcase
        settle();
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_FG_COLOR, fg);
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_BG_COLOR, bg);
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_WIDTH, {19'($urandom), width});
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_PITCH, {19'($urandom), pitch});
        write_reg(CFG_HEIGHT, {26'($urandom), height});
        cfg_we <= 1'b0;
        font_rows = (height == 0) ? 1 : (height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : height;
    endtask

    // Stimulus
    initial begin
        logic [7:0]   pattern [6];
        logic [7:0]   code;
        logic [12:0]  px;
        logic [12:0]  py;
        int           r;
        int           ready;
        int           pick;
        int           phase;
        int           next_phase;

        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one full glyph at reset settings, corner positions, wrap
        for (r = 0; r < font_rows; r++) begin
            send_item(FN_LOAD, 8'h41, 5'(r), (r < 6) ? pattern[r] : 8'($urandom),
                      13'($urandom), 13'($urandom));
            row_loaded[8'h41][r] = 1'b1;
        end
        draw_char(8'h41);
        // cursor row saturation
        place_cursor(13'd8191, 13'd8191);
        draw_char(8'h41);
        // right edge: three draws fit, the cursor wraps after the third
        place_cursor(13'd1000, 13'd0);
        repeat (3) draw_char(8'h41);
        // unused function code is ignored
        send_item(FN_NONE, 8'($urandom), 5'($urandom), 8'($urandom),
                  13'($urandom), 13'($urandom));

        // Random: load-then-draw sequences, text runs, noise and reconfiguration
        items_sent = 0;
        phase = 0;
        next_phase = 10;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= next_phase) begin
                config_phase(phase);
                phase++;
                next_phase = items_sent + $urandom_range(30, 70);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                code = 8'($urandom);
                load_glyph(code);
                repeat ($urandom_range(1, 3)) draw_char(code);
            end
            else if (pick < 60) begin
                repeat ($urandom_range(1, 8)) begin
                    ready = find_ready_glyph();
                    if (ready < 0) begin
                        ready = $urandom_range(0, GLYPH_COUNT - 1);
                        load_glyph(8'(ready));
                    end
                    draw_char(8'(ready));
                end
            end
            else if (pick < 72) begin
                px = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(8000, 8191))
                                                 : 13'($urandom);
                py = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 600))
                                                 : 13'($urandom);
                place_cursor(px, py);
            end
            else if (pick < 86) begin
                // stray row load, overwrites or starts a glyph
                code = 8'($urandom);
                r = $urandom_range(0, MAX_GLYPH_HEIGHT - 1);
                send_item(FN_LOAD, code, 5'(r), 8'($urandom), 13'($urandom), 13'($urandom));
                row_loaded[code][r] = 1'b1;
            end
            else if (pick < 94) begin
                send_item(FN_NONE, 8'($urandom), 5'($urandom), 8'($urandom),
                          13'($urandom), 13'($urandom));
            end
            else begin
                settle();
            end
        end

        settle();
        if (mismatches == 0 && rows_due == 0)
            $display("PASS glyph_text_renderer_top");
        else
            $display("FAIL glyph_text_renderer_top");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("FAIL glyph_text_renderer_top");
        $finish;
    end

endmodule
